FILE: sv/tih_pkg.sv
`timescale 1ns / 1ps
// Package for the tour insertion unit: sizes, fixed-point widths,
// controller/datapath command and status structs, helper functions.
// No dependencies.
package tih_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int COORD_BITS  = 16;
  localparam int SLOT_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int FRAC_BITS   = 8;
  localparam int D2_W        = 2 * COORD_BITS + 1;
  localparam int ROOT_STEPS  = (D2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int VAL_W       = 2 * ROOT_STEPS;
  localparam int ROOT_W      = ROOT_STEPS + 1;
  localparam int REM_W       = ROOT_W + 2;
  localparam int COST_W      = ROOT_W + 3;
  localparam int STEP_W      = $clog2(ROOT_STEPS + 1);
  localparam int LEN_W       = 35;
  localparam int ADD_W       = 25;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic MODE_NEAREST  = 1'b0;
  localparam logic MODE_CHEAPEST = 1'b1;

  typedef struct packed {
    logic start;
    logic rd;
    logic load;
    logic mul;
    logic sum;
    logic ncmp;
    logic seek;
    logic root_go;
    logic cost;
    logic link_a;
    logic link_b;
    logic finish;
  } tih_cmd_t;

  typedef struct packed {
    logic full;
    logic first;
    logic mode;
    logic fin;
    logic k_zero;
    logic near_end;
    logic cheap_end;
    logic root_done;
    logic out_free;
  } tih_stat_t;

  function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: sv/tour_insertion_heuristic_unit.sv
`timescale 1ns / 1ps
// Tour insertion unit top level: controller plus datapath.
// Depends on tih_pkg, tih_ctrl, tih_dp.
//
// Each accepted point, unless the tables are full, is written to the next free slot and
// linked into the closed tour kept in on-chip node tables; one result word follows per
// point. The unit works on one point at a time and takes the next input as soon as the
// previous result is loaded into the output register. The tour walk visits nodes one by
// one through a single read port of the node tables. Nearest mode reads, squares and
// compares each tour node and runs the square roots only for the final edge; cheapest
// mode runs the shared distance and square-root datapath on every edge, through the
// 25-step iterative root. Full or first points skip the walk and go straight to the output.
module tour_insertion_heuristic_unit import tih_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic [SLOT_W-1:0]     new_slot,
  output logic [SLOT_W-1:0]     after_slot,
  output logic [CNT_W-1:0]      point_count,
  output logic [ADD_W-1:0]      added_length,
  output logic [LEN_W-1:0]      tour_length
);

  tih_cmd_t  cmd;
  tih_stat_t st;

  tih_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .st(st)
  );

  tih_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .point_x(point_x), .point_y(point_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .new_slot(new_slot), .after_slot(after_slot),
    .point_count(point_count), .added_length(added_length), .tour_length(tour_length)
  );

endmodule

FILE: sv/tih_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tih_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/tih_root.sv
`timescale 1ns / 1ps
// Iterative rounded square root in Q8: round(sqrt(d2) * 256), one bit pair per cycle.
// Depends on tih_pkg.
module tih_root import tih_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [D2_W-1:0]   d2,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic [VAL_W-1:0]  val;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic [REM_W+1:0]  rem_s;
  logic [REM_W+1:0]  trial;

  assign rem_s = {rem, val[VAL_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      val  <= VAL_W'({d2, {(2 * FRAC_BITS){1'b0}}});
      rem  <= '0;
      root <= '0;
      cnt  <= STEP_W'(ROOT_STEPS);
    end else if (busy) begin
      if (cnt != '0) begin
        val <= val << 2;
        cnt <= cnt - 1'b1;
        if (rem_s >= trial) begin
          rem  <= REM_W'(rem_s - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(rem_s);
          root <= {root[ROOT_W-2:0], 1'b0};
        end
      end else if (REM_W'(rem) > REM_W'(root)) begin
        root <= root + 1'b1;
      end
    end
  end

endmodule

FILE: sv/tih_dp.sv
`timescale 1ns / 1ps
// Datapath of the tour insertion unit: node tables, tour walk registers,
// distance squares, three root units, cost select, length totals, output word.
// Depends on tih_pkg, tih_ram, tih_root.
module tih_dp import tih_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  tih_cmd_t              cmd,
  output tih_stat_t             st,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  status,
  output logic [SLOT_W-1:0]     new_slot,
  output logic [SLOT_W-1:0]     after_slot,
  output logic [CNT_W-1:0]      point_count,
  output logic [ADD_W-1:0]      added_length,
  output logic [LEN_W-1:0]      tour_length
);

  logic                    mode;
  logic [CNT_W-1:0]        count;
  logic [LEN_W-1:0]        sum;
  logic [COORD_BITS-1:0]   px, py, cur_x, cur_y, prev_x, prev_y, best_x, best_y;
  logic [SLOT_W-1:0]       cur_slot, cur_id, cur_next, prev_id, best_after, best_next;
  logic [CNT_W-1:0]        k;
  logic                    fin;
  logic [D2_W-1:0]         best_sq;
  logic signed [COST_W-1:0] best_cost;
  logic [2*COORD_BITS-1:0] sq_apx, sq_apy, sq_bpx, sq_bpy, sq_abx, sq_aby;
  logic [D2_W-1:0]         d2_ap, d2_bp, d2_ab;
  logic [ROOT_W-1:0]       r_ap, r_bp, r_ab;
  logic                    done_ap, done_bp, done_ab;
  logic signed [COST_W-1:0] cost;
  logic                    take;

  logic [COORD_BITS-1:0]   x_rd, y_rd;
  logic [SLOT_W-1:0]       n_rd;
  logic                    xy_we, n_we;
  logic [SLOT_W-1:0]       n_waddr, n_wdata;

  logic                    full, first;
  logic [CNT_W-1:0]        count_inc;
  logic signed [LEN_W+1:0] sum_ext;
  logic [LEN_W-1:0]        sum_next;
  logic [ADD_W-1:0]        added;

  assign full      = count >= CNT_W'(MAX_NODES);
  assign first     = count == '0;
  assign count_inc = count + 1'b1;

  assign xy_we   = cmd.start && !full;
  assign n_we    = (cmd.start && first) || cmd.link_a || cmd.link_b;
  assign n_waddr = cmd.link_b ? best_after : (cmd.link_a ? count[SLOT_W-1:0] : '0);
  assign n_wdata = cmd.link_b ? count[SLOT_W-1:0] : (cmd.link_a ? best_next : '0);

  tih_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_x_table (
    .clk(clk), .we(xy_we), .waddr(count[SLOT_W-1:0]), .wdata(point_x),
    .raddr(cur_slot), .rdata(x_rd)
  );

  tih_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_NODES)) u_y_table (
    .clk(clk), .we(xy_we), .waddr(count[SLOT_W-1:0]), .wdata(point_y),
    .raddr(cur_slot), .rdata(y_rd)
  );

  tih_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_NODES)) u_next_table (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(cur_slot), .rdata(n_rd)
  );

  tih_root u_root_ap (.clk(clk), .rst(rst), .go(cmd.root_go), .d2(d2_ap),
                      .done(done_ap), .root(r_ap));
  tih_root u_root_bp (.clk(clk), .rst(rst), .go(cmd.root_go), .d2(d2_bp),
                      .done(done_bp), .root(r_bp));
  tih_root u_root_ab (.clk(clk), .rst(rst), .go(cmd.root_go), .d2(d2_ab),
                      .done(done_ab), .root(r_ab));

  assign cost = $signed(COST_W'(r_ap)) + $signed(COST_W'(r_bp)) - $signed(COST_W'(r_ab));
  assign take = fin || (k == CNT_W'(2)) || (cost < best_cost);

  assign sum_ext = $signed({2'b00, sum})
                 + $signed({{(LEN_W + 2 - COST_W){best_cost[COST_W-1]}}, best_cost});

  always_comb begin
    if (sum_ext[LEN_W+1]) begin
      sum_next = '0;
    end else if (sum_ext[LEN_W]) begin
      sum_next = '1;
    end else begin
      sum_next = sum_ext[LEN_W-1:0];
    end
    if (best_cost[COST_W-1]) begin
      added = '0;
    end else if (|best_cost[COST_W-2:ADD_W]) begin
      added = '1;
    end else begin
      added = best_cost[ADD_W-1:0];
    end
  end

  assign st.full      = full;
  assign st.first     = first;
  assign st.mode      = mode;
  assign st.fin       = fin;
  assign st.k_zero    = k == '0;
  assign st.near_end  = k == count;
  assign st.cheap_end = k == count_inc;
  assign st.root_done = done_ap;
  assign st.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_CHEAPEST;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mode <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (!full) begin
          count <= count_inc;
          sum   <= first ? '0 : sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px       <= point_x;
      py       <= point_y;
      k        <= '0;
      fin      <= 1'b0;
      cur_slot <= '0;
    end
    if (cmd.load) begin
      prev_x   <= cur_x;
      prev_y   <= cur_y;
      prev_id  <= cur_id;
      cur_x    <= x_rd;
      cur_y    <= y_rd;
      cur_next <= n_rd;
      cur_id   <= cur_slot;
      cur_slot <= n_rd;
      k        <= k + 1'b1;
    end
    if (cmd.mul) begin
      sq_apx <= abs_diff(prev_x, px) * abs_diff(prev_x, px);
      sq_apy <= abs_diff(prev_y, py) * abs_diff(prev_y, py);
      sq_bpx <= abs_diff(cur_x, px) * abs_diff(cur_x, px);
      sq_bpy <= abs_diff(cur_y, py) * abs_diff(cur_y, py);
      sq_abx <= abs_diff(prev_x, cur_x) * abs_diff(prev_x, cur_x);
      sq_aby <= abs_diff(prev_y, cur_y) * abs_diff(prev_y, cur_y);
    end
    if (cmd.sum) begin
      d2_ap <= D2_W'(sq_apx) + D2_W'(sq_apy);
      d2_bp <= D2_W'(sq_bpx) + D2_W'(sq_bpy);
      d2_ab <= D2_W'(sq_abx) + D2_W'(sq_aby);
    end
    if (cmd.ncmp && (k == CNT_W'(1) || d2_bp < best_sq)) begin
      best_sq    <= d2_bp;
      best_x     <= cur_x;
      best_y     <= cur_y;
      best_after <= cur_id;
      best_next  <= cur_next;
    end
    if (cmd.seek) begin
      cur_x    <= best_x;
      cur_y    <= best_y;
      cur_id   <= best_after;
      cur_slot <= best_next;
      fin      <= 1'b1;
    end
    if (cmd.cost && take) begin
      best_cost  <= cost;
      best_after <= prev_id;
      best_next  <= cur_id;
    end
    if (cmd.finish) begin
      status       <= full ? STATUS_FULL : STATUS_OK;
      new_slot     <= full ? '0 : count[SLOT_W-1:0];
      after_slot   <= (full || first) ? '0 : best_after;
      point_count  <= full ? count : count_inc;
      added_length <= (full || first) ? '0 : added;
      tour_length  <= full ? sum : (first ? '0 : sum_next);
    end
  end

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting word");

  a_roots_agree: assert property (@(posedge clk) disable iff (rst)
    done_ap |-> (done_bp && done_ab))
    else $error("root units out of step");

  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (k <= count))
    else $error("tour walk ran past the node count");

endmodule

FILE: sv/tih_ctrl.sv
`timescale 1ns / 1ps
// Controller of the tour insertion unit: sequences the walk, root units and
// link writes through command and status structs.
// Depends on tih_pkg.
module tih_ctrl import tih_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output tih_cmd_t  cmd,
  input  tih_stat_t st
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_LOAD  = 13'b0000000000100,
    S_MUL   = 13'b0000000001000,
    S_SUM   = 13'b0000000010000,
    S_NCMP  = 13'b0000000100000,
    S_SEEK  = 13'b0000001000000,
    S_RGO   = 13'b0000010000000,
    S_RWAIT = 13'b0000100000000,
    S_COST  = 13'b0001000000000,
    S_LINKA = 13'b0010000000000,
    S_LINKB = 13'b0100000000000,
    S_OUT   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = (st.full || st.first) ? S_OUT : S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = (st.mode == MODE_CHEAPEST && st.k_zero && !st.fin) ? S_RD : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = (st.mode == MODE_NEAREST && !st.fin) ? S_NCMP : S_RGO;
      end
      S_NCMP: begin
        cmd.ncmp   = 1'b1;
        state_next = st.near_end ? S_SEEK : S_RD;
      end
      S_SEEK: begin
        cmd.seek   = 1'b1;
        state_next = S_RD;
      end
      S_RGO: begin
        cmd.root_go = 1'b1;
        state_next  = S_RWAIT;
      end
      S_RWAIT: begin
        if (st.root_done) begin
          state_next = S_COST;
        end
      end
      S_COST: begin
        cmd.cost   = 1'b1;
        state_next = (st.fin || st.cheap_end) ? S_LINKA : S_RD;
      end
      S_LINKA: begin
        cmd.link_a = 1'b1;
        state_next = S_LINKB;
      end
      S_LINKB: begin
        cmd.link_b = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_locks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word taken during an insertion");

  a_root_wait: assert property (@(posedge clk) disable iff (rst)
    st.root_done |-> state == S_RWAIT)
    else $error("root result outside the wait state");

  a_link_order: assert property (@(posedge clk) disable iff (rst)
    cmd.link_b |-> $past(cmd.link_a))
    else $error("second link write without the first");

endmodule
